// ===== hdl/jse_pkg.sv =====
// Shared types, character codes and helpers for the JSON string escaper.
// No dependencies; used by jse_escape and json_string_escaper_truncating.
package jse_pkg;

    localparam int unsigned LIMIT_MAX = 4096;
    localparam int unsigned CNT_W     = 13;

    // Configuration register indexes
    localparam logic CFG_MAX_INPUT = 1'b0;
    localparam logic CFG_OUT_CAP   = 1'b1;

    // Reset values of the configuration registers
    localparam logic [CNT_W-1:0] MAX_INPUT_RST = 13'd220;
    localparam logic [CNT_W-1:0] OUT_CAP_RST   = 13'd480;

    // Character codes
    localparam logic [7:0] CH_QUOTE   = 8'd34;
    localparam logic [7:0] CH_BSLASH  = 8'd92;
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_N       = 8'd110;
    localparam logic [7:0] CH_R       = 8'd114;
    localparam logic [7:0] CH_T       = 8'd116;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_NUL     = 8'd0;

    typedef struct packed {
        logic [7:0] data;
        logic       term;
    } jse_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] seen;
        logic [CNT_W-1:0] written;
        logic             halted;
    } jse_state_t;

    typedef struct packed {
        logic [1:0]      cnt;
        jse_item_t [2:0] items;
    } jse_result_t;

    // Saturate a written register value at LIMIT_MAX
    function automatic logic [CNT_W-1:0] clamp_reg(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] lim;
        lim = CNT_W'(LIMIT_MAX);
        return (v > lim) ? lim : v;
    endfunction

endpackage

// ===== hdl/json_string_escaper_truncating.sv =====
// Top level of the truncating JSON string escaper: input register, escape logic, result buffer.
// Depends on jse_pkg and jse_escape.
//
// Streams a message in one byte per request and returns a JSON-escaped preview, one byte per
// request on the output. Quote and backslash come out as backslash plus the byte; LF, CR and
// TAB as \n, \r, \t; other control bytes are dropped. Only the first max_input_limit bytes
// count, and the preview stops for the rest of the message at out_capacity - 1 bytes or when
// an escape pair no longer fits. The request carrying in_last also yields a terminator
// request (out_byte 0, out_end 1) and clears the message counters. A plain byte yields one
// output byte, a dropped byte none, an escaped byte two, and the final byte one more for the
// terminator; the output port moves one byte per cycle while out_stall is low. A request passes
// through the input register and then the result buffer before its first output appears. Each
// input request parks in a one-entry input register, so a new request can be taken while a
// result is still waiting on out_stall. Configuration: index 0 = max_input_limit, index 1 =
// out_capacity, both 13 bits, saturated at 4096, always ready; write only while the block is idle.
module json_string_escaper_truncating
    import jse_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       in_byte,
    input  logic             in_last,

    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic             out_end,

    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [CNT_W-1:0] cfg_data
);

    // Configuration registers
    logic [CNT_W-1:0] max_input_reg;
    logic [CNT_W-1:0] out_cap_reg;

    // Input register
    logic             in_vld_reg;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;

    // Message state
    jse_state_t       st_reg;
    jse_state_t       st_next;

    // Result buffer: up to three pending output items, head at index 0
    jse_item_t [2:0]  buf_reg;
    logic [1:0]       cnt_reg;

    jse_result_t      res;
    logic             in_take;
    logic             out_take;
    logic             consume;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_input_reg <= MAX_INPUT_RST;
            out_cap_reg   <= OUT_CAP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAX_INPUT: max_input_reg <= clamp_reg(cfg_data);
                CFG_OUT_CAP:   out_cap_reg   <= clamp_reg(cfg_data);
                default:       max_input_reg <= max_input_reg;
            endcase
        end
    end

    jse_escape u_escape (
        .c         (in_byte_reg),
        .last      (in_last_reg),
        .max_input (max_input_reg),
        .out_cap   (out_cap_reg),
        .st        (st_reg),
        .st_next   (st_next),
        .res       (res)
    );

    assign out_valid = (cnt_reg != 2'd0);
    assign out_byte  = buf_reg[0].data;
    assign out_end   = buf_reg[0].term;
    assign out_take  = out_valid && !out_stall;

    // The held byte moves on once the buffer drains this cycle
    assign consume  = in_vld_reg && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_take));
    assign in_stall = in_vld_reg && !consume;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (consume)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= in_byte;
            in_last_reg <= in_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= '0;
            cnt_reg <= 2'd0;
        end
        else if (consume)
        begin
            st_reg  <= st_next;
            cnt_reg <= res.cnt;
        end
        else if (out_take)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume)
        begin
            buf_reg <= res.items;
        end
        else if (out_take)
        begin
            buf_reg[0] <= buf_reg[1];
            buf_reg[1] <= buf_reg[2];
        end
    end

    // The terminator is always the final pending item
    a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_end) |-> (cnt_reg == 2'd1))
        else $error("terminator not at tail of result buffer");

    // The preview never grows past the largest buffer
    a_written_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.written <= CNT_W'(LIMIT_MAX - 1))
        else $error("written count beyond limit");

    // The last byte of a message clears the message state
    a_msg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && in_last_reg) |=> (st_reg == '0))
        else $error("message state not cleared after last byte");

    // A stalled input always has a byte waiting in the input register
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_stall) |=> in_vld_reg)
        else $error("input stalled with empty input register");

endmodule

// ===== hdl/jse_escape.sv =====
// Per-byte escape and truncation logic: next message state and up to three result items.
// Depends on jse_pkg.
module jse_escape
    import jse_pkg::*;
(
    input  logic [7:0]       c,
    input  logic             last,
    input  logic [CNT_W-1:0] max_input,
    input  logic [CNT_W-1:0] out_cap,
    input  jse_state_t       st,
    output jse_state_t       st_next,
    output jse_result_t      res
);

    logic [CNT_W-1:0] cap;
    logic [CNT_W:0]   wr_p1;
    logic [CNT_W:0]   wr_p2;
    logic             esc_hit;
    logic             emit;
    logic [7:0]       esc_ch;

    assign cap   = (out_cap == '0) ? CNT_W'(1) : out_cap;
    assign wr_p1 = {1'b0, st.written} + (CNT_W+1)'(1);
    assign wr_p2 = {1'b0, st.written} + (CNT_W+1)'(2);

    always_comb
    begin
        esc_hit = 1'b1;
        emit    = 1'b1;
        esc_ch  = c;
        case (c)
            CH_QUOTE:  esc_ch = CH_QUOTE;
            CH_BSLASH: esc_ch = CH_BSLASH;
            CH_LF:     esc_ch = CH_N;
            CH_CR:     esc_ch = CH_R;
            CH_TAB:    esc_ch = CH_T;
            default:
            begin
                esc_hit = 1'b0;
                emit    = (c >= CH_SPACE);
            end
        endcase
    end

    always_comb
    begin
        st_next   = st;
        res.cnt   = 2'd0;
        res.items = '0;

        if (!st.halted && (st.seen < max_input))
        begin
            if (wr_p1 >= {1'b0, cap})
            begin
                st_next.halted = 1'b1;
            end
            else
            begin
                st_next.seen = st.seen + CNT_W'(1);
                if (esc_hit)
                begin
                    if (wr_p2 >= {1'b0, cap})
                    begin
                        st_next.halted = 1'b1;
                    end
                    else
                    begin
                        res.items[0]    = '{data: CH_BSLASH, term: 1'b0};
                        res.items[1]    = '{data: esc_ch, term: 1'b0};
                        res.cnt         = 2'd2;
                        st_next.written = wr_p2[CNT_W-1:0];
                    end
                end
                else if (emit)
                begin
                    res.items[0]    = '{data: c, term: 1'b0};
                    res.cnt         = 2'd1;
                    st_next.written = wr_p1[CNT_W-1:0];
                end
            end
        end

        // Terminator goes after whatever preview bytes this byte produced
        if (last)
        begin
            case (res.cnt)
                2'd0:    res.items[0] = '{data: CH_NUL, term: 1'b1};
                2'd1:    res.items[1] = '{data: CH_NUL, term: 1'b1};
                default: res.items[2] = '{data: CH_NUL, term: 1'b1};
            endcase
            res.cnt = res.cnt + 2'd1;
            st_next = '0;
        end
    end

endmodule

// ===== dv/tb_json_string_escaper_truncating.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the truncating JSON string escaper.
// Depends on jse_pkg and the RTL top json_string_escaper_truncating, which needs jse_escape.
module tb_json_string_escaper_truncating;
    import jse_pkg::*;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    // Block ports; every input starts at a known value
    logic             in_valid  = 1'b0;
    logic             in_stall;
    logic [7:0]       in_byte   = 8'd0;
    logic             in_last   = 1'b0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [7:0]       out_byte;
    logic             out_end;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic             cfg_index = CFG_MAX_INPUT;
    logic [CNT_W-1:0] cfg_data  = '0;

    json_string_escaper_truncating DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_end   (out_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // One input request: a message byte and its last flag
    typedef struct {
        logic [7:0] msg_byte;
        logic       msg_last;
    } msg_req_t;

    msg_req_t  pending_reqs[$];      // requests not yet offered to the block
    jse_item_t preview_expected[$];  // predicted preview bytes and terminators, oldest first

    int unsigned err_count = 0;
    bit          no_idle   = 1'b0;   // set for phases that run with no gaps on either side

    // Handshake history from the last rising edge, used by the falling-edge drivers
    logic in_taken  = 1'b0;
    logic out_fired = 1'b0;

    // Predictor copy of the registers and the per-message counters
    logic [CNT_W-1:0] lim_input       = MAX_INPUT_RST;
    logic [CNT_W-1:0] lim_capacity    = OUT_CAP_RST;
    logic [CNT_W-1:0] msg_consumed    = '0;
    logic [CNT_W-1:0] preview_len     = '0;
    logic             preview_stopped = 1'b0;

    // Register writes saturate at LIMIT_MAX
    function automatic logic [CNT_W-1:0] sat_limit(input logic [CNT_W-1:0] v);
        return (v > CNT_W'(LIMIT_MAX)) ? CNT_W'(LIMIT_MAX) : v;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Byte mix leaning on the escaped and dropped classes
    function automatic logic [7:0] rand_msg_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return CH_QUOTE;
        else if (r < 16)
            return CH_BSLASH;
        else if (r < 22)
            return CH_LF;
        else if (r < 28)
            return CH_CR;
        else if (r < 34)
            return CH_TAB;
        else if (r < 44)
            return 8'($urandom_range(0, 31));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // Small limits hit truncation often; the extremes and the saturating
    // range above LIMIT_MAX come up too.
    function automatic logic [CNT_W-1:0] pick_input_limit();
        case ($urandom_range(0, 9))
            0:       return 13'd0;
            1:       return 13'd1;
            2:       return 13'd2;
            3:       return 13'd3;
            4:       return 13'd5;
            5:       return 13'd8;
            6:       return 13'd20;
            7:       return 13'd4096;
            8:       return 13'd8191;
            default: return 13'($urandom_range(0, 8191));
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] pick_capacity();
        case ($urandom_range(0, 9))
            0:       return 13'd0;
            1:       return 13'd1;
            2:       return 13'd2;
            3:       return 13'd3;
            4:       return 13'd4;
            5:       return 13'd7;
            6:       return 13'd12;
            7:       return 13'd4096;
            8:       return 13'd8191;
            default: return 13'($urandom_range(0, 8191));
        endcase
    endfunction

    // Work out the preview items that one accepted request causes
    task automatic predict_preview(input logic [7:0] c, input logic last);
        logic [CNT_W-1:0] cap;
        logic [7:0]       esc;
        logic             keep;
        cap = (lim_capacity == '0) ? CNT_W'(1) : lim_capacity;
        if (!preview_stopped && msg_consumed < lim_input) begin
            // Buffer already holds capacity - 1 bytes: stop for this message
            if (preview_len + 1 >= cap) begin
                preview_stopped = 1'b1;
            end
            else begin
                msg_consumed = msg_consumed + 1'b1;
                esc  = CH_NUL;
                keep = 1'b1;
                case (c)
                    CH_QUOTE, CH_BSLASH: esc = c;
                    CH_LF:               esc = CH_N;
                    CH_CR:               esc = CH_R;
                    CH_TAB:              esc = CH_T;
                    default:             keep = (c >= CH_SPACE);  // other controls dropped
                endcase
                if (esc != CH_NUL) begin
                    // An escape pair goes out whole or not at all
                    if (preview_len + 2 >= cap) begin
                        preview_stopped = 1'b1;
                    end
                    else begin
                        preview_expected.push_back('{data: CH_BSLASH, term: 1'b0});
                        preview_expected.push_back('{data: esc, term: 1'b0});
                        preview_len = preview_len + 2'd2;
                    end
                end
                else if (keep) begin
                    preview_expected.push_back('{data: c, term: 1'b0});
                    preview_len = preview_len + 1'b1;
                end
            end
        end
        // The last byte closes the preview and clears the message counters
        if (last) begin
            preview_expected.push_back('{data: CH_NUL, term: 1'b1});
            msg_consumed    = '0;
            preview_len     = '0;
            preview_stopped = 1'b0;
        end
    endtask

    // Input driver: offers queued requests at the falling edge, holds a
    // request until it is taken, and inserts random gaps between requests.
    int unsigned in_gap = 0;

    always @(negedge clk) begin : in_driver
        msg_req_t req;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !in_taken) begin
            // stalled: payload stays as it is
        end
        else if (in_gap > 0) begin
            in_valid <= 1'b0;
            in_gap   <= in_gap - 1;
        end
        else if (pending_reqs.size() > 0) begin
            req       = pending_reqs.pop_front();
            in_valid <= 1'b1;
            in_byte  <= req.msg_byte;
            in_last  <= req.msg_last;
            in_gap   <= idle_len();
        end
        else begin
            in_valid <= 1'b0;
        end
    end

    // Output stall generator: after a result is taken, sometimes hold off for
    // a random stretch. Stall never looks at out_valid within the cycle.
    int unsigned out_hold = 0;

    always @(negedge clk) begin
        if (!rst_n || no_idle) begin
            out_stall <= 1'b0;
            out_hold  <= 0;
        end
        else if (out_hold > 0) begin
            out_stall <= 1'b1;
            out_hold  <= out_hold - 1;
        end
        else begin
            out_stall <= 1'b0;
            if (out_fired)
                out_hold <= idle_len();
        end
    end

    // Monitor: at each rising edge, run the predictor on an accepted request
    // and compare an accepted result with the oldest expectation.
    always @(posedge clk) begin : monitor
        jse_item_t exp_item;
        in_taken  <= in_valid && !in_stall;
        out_fired <= out_valid && !out_stall;
        if (rst_n && in_valid && !in_stall)
            predict_preview(in_byte, in_last);
        if (rst_n && out_valid && !out_stall) begin
            if (preview_expected.size() == 0) begin
                $error("unexpected result: out_byte %0d out_end %0d", out_byte, out_end);
                err_count++;
            end
            else begin
                exp_item = preview_expected.pop_front();
                if (out_byte !== exp_item.data) begin
                    $error("out_byte mismatch: expected %0d, actual %0d",
                           exp_item.data, out_byte);
                    err_count++;
                end
                if (out_end !== exp_item.term) begin
                    $error("out_end mismatch: expected %0d, actual %0d",
                           exp_item.term, out_end);
                    err_count++;
                end
            end
        end
    end

    // Register write through the config channel; the predictor picks up the
    // new value once the write handshake completes.
    task automatic write_reg(input logic idx, input logic [CNT_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_MAX_INPUT)
            lim_input = sat_limit(val);
        else
            lim_capacity = sat_limit(val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_req(input logic [7:0] b, input logic last);
        pending_reqs.push_back('{msg_byte: b, msg_last: last});
    endtask

    task automatic queue_message(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            push_req(rand_msg_byte(), i == len - 1);
    endtask

    // Wait until every request is taken and every result is back, then give
    // dropped bytes still in flight time to drain. Checked at the rising
    // edge, where the driver's queue and valid are settled.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || in_valid || preview_expected.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    // Stimulus sequence
    initial begin : stimulus
        int unsigned phase_items;
        int unsigned len;
        int unsigned drain;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: every byte class in one message, with 0 and 255
        push_req(8'd0, 1'b0);
        push_req(8'd255, 1'b0);
        push_req(CH_QUOTE, 1'b0);
        push_req(CH_BSLASH, 1'b0);
        push_req(CH_LF, 1'b0);
        push_req(CH_CR, 1'b0);
        push_req(CH_TAB, 1'b0);
        push_req(8'd31, 1'b0);
        push_req(CH_SPACE, 1'b0);
        push_req(8'd127, 1'b1);
        wait_idle();

        // Input limit of zero: only the terminator comes out
        write_reg(CFG_MAX_INPUT, 13'd0);
        @(posedge clk);
        push_req(CH_QUOTE, 1'b0);
        push_req(8'd97, 1'b0);
        push_req(8'd98, 1'b1);
        wait_idle();

        // Input limit reached after three bytes; capacity above range saturates
        write_reg(CFG_MAX_INPUT, 13'd3);
        write_reg(CFG_OUT_CAP, 13'd8191);
        @(posedge clk);
        push_req(8'd97, 1'b0);
        push_req(CH_LF, 1'b0);
        push_req(8'd98, 1'b0);
        push_req(8'd99, 1'b0);
        push_req(8'd100, 1'b1);
        wait_idle();

        // Zero capacity behaves like one: nothing but terminators
        write_reg(CFG_MAX_INPUT, 13'd8191);
        write_reg(CFG_OUT_CAP, 13'd0);
        @(posedge clk);
        push_req(8'd120, 1'b0);
        push_req(8'd121, 1'b1);
        wait_idle();

        // Capacity 3: a second-byte escape no longer fits, a first-byte one does
        write_reg(CFG_OUT_CAP, 13'd3);
        @(posedge clk);
        push_req(8'd97, 1'b0);
        push_req(CH_QUOTE, 1'b0);
        push_req(8'd98, 1'b1);
        push_req(CH_BSLASH, 1'b1);
        wait_idle();

        // Capacity 2: buffer full after one byte
        write_reg(CFG_OUT_CAP, 13'd2);
        @(posedge clk);
        push_req(8'd97, 1'b0);
        push_req(8'd98, 1'b0);
        push_req(CH_TAB, 1'b1);
        wait_idle();

        // Random phases, each with its own register setting; some run flat out
        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_MAX_INPUT, pick_input_limit());
            write_reg(CFG_OUT_CAP, pick_capacity());
            @(posedge clk);
            no_idle     = ($urandom_range(0, 3) == 0);
            phase_items = 0;
            while (phase_items < 30) begin
                len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 12)
                                                   : $urandom_range(13, 50);
                queue_message(len);
                phase_items += len;
            end
            wait_idle();
        end

        // Back to the reset setting for a last burst of messages
        write_reg(CFG_MAX_INPUT, 13'd220);
        write_reg(CFG_OUT_CAP, 13'd480);
        @(posedge clk);
        no_idle = 1'b0;
        for (int m = 0; m < 4; m++)
            queue_message($urandom_range(1, 16));

        // Final drain: all requests taken, then a bounded wait for the results
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || in_valid);
        drain = 0;
        while (preview_expected.size() != 0 && drain < 4000) begin
            @(negedge clk);
            drain++;
        end
        repeat (10) @(negedge clk);
        if (preview_expected.size() != 0) begin
            $error("%0d expected results never arrived", preview_expected.size());
            err_count++;
        end

        if (err_count == 0)
            $display("tb_json_string_escaper_truncating: PASS");
        else
            $display("tb_json_string_escaper_truncating: FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("tb_json_string_escaper_truncating: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/jse_pkg.sv
hdl/jse_escape.sv
hdl/json_string_escaper_truncating.sv
dv/tb_json_string_escaper_truncating.sv
